[sv/rwt_pkg.sv]
`default_nettype none

package rwt_pkg;

   // request operation codes (req_tuser)
   localparam logic [1:0] OP_SEND   = 2'd0;
   localparam logic [1:0] OP_RESEND = 2'd1;
   localparam logic [1:0] OP_ACK    = 2'd2;

   // one response item
   typedef struct packed {
      logic        wraps;
      logic [15:0] out_length;
      logic [15:0] start_offset;
      logic [7:0]  seq_num;
      logic        accepted;
   } rsp_item_type;

endpackage

`default_nettype wire

[sv/retransmit_window_tracker.sv]
`default_nettype none

// Retransmit window tracker. Keeps the bookkeeping of a sliding-window
// retransmit buffer: messages sit end to end in a byte ring of RING_BYTES
// bytes and a table of SEQ_SPACE end offsets, indexed by sequence number,
// records where each one ends. A request (req_tuser = send, resend all or
// acknowledge) yields exactly one response. Each request has a read cycle,
// which reads the acked and next entries out of the offset table memory,
// and an update cycle, which updates and writes the entry back; the next
// request is taken in the cycle after that, so a new request is not taken
// before the last one is through. A response waiting in the output register
// does not block the read cycle of the next request; the update cycle waits
// until the output is free. After reset the table is cleared one entry per
// cycle, with req_tready low during that pass.
module retransmit_window_tracker import rwt_pkg::*; #(
   parameter int SEQ_SPACE = 256,
   parameter int RING_BYTES = 65536
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // msg_length[15:0], ack_seq[23:16]
   input  wire logic [1:0]  req_tuser,   // op[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // accepted[0], seq_num[8:1], start_offset[24:9], out_length[40:25],
   // wraps[41], zero fill[47:42]
   output logic [47:0]      rsp_tdata
);

   localparam int SW = $clog2(SEQ_SPACE);
   localparam int OW = $clog2(RING_BYTES);
   localparam logic [SW:0] SEQ_L = (SW + 1)'(SEQ_SPACE);
   localparam logic [SW-1:0] SEQ_LAST = SW'(SEQ_SPACE - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   typedef logic [SW-1:0] seq_map_type [256];

   // ack_seq folded into the sequence space
   function automatic seq_map_type build_ack_map();
      seq_map_type m;
      for (int i = 0; i < 256; i++) begin
         m[i] = SW'(i % SEQ_SPACE);
      end
      return m;
   endfunction

   localparam seq_map_type ACK_MAP = build_ack_map();

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] clr_addr_ff, clr_addr_in;
   logic [SW-1:0] next_seq_ff, next_seq_in;
   logic [SW-1:0] acked_seq_ff, acked_seq_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   rsp_item_type  rsp_item_ff;

   // request held for the update cycle
   logic [1:0]    op_ff;
   logic [15:0]   len_ff;
   logic [SW-1:0] ack_idx_ff;

   logic          req_go;
   logic          exec_go;
   logic [SW-1:0] req_ack_idx;
   logic [SW-1:0] rd_a_addr;
   logic [OW-1:0] rd_a_data;
   logic [OW-1:0] rd_b_data;
   logic          mem_wr_en;
   logic [SW-1:0] mem_wr_addr;
   logic [OW-1:0] mem_wr_data;

   rsp_item_type  upd_rsp;
   logic          upd_wr_en;
   logic [SW-1:0] upd_wr_addr;
   logic [OW-1:0] upd_wr_data;
   logic [SW-1:0] upd_next_seq;
   logic [SW-1:0] upd_acked_seq;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_go      = req_tvalid && req_tready;
   assign exec_go     = (state_ff == ST_EXEC) && (!rsp_tvalid_ff || rsp_tready);
   assign req_ack_idx = ACK_MAP[req_tdata[23:16]];

   // acknowledge reports the entry at the new acked sequence
   assign rd_a_addr = (req_tuser == OP_ACK) ? req_ack_idx : acked_seq_ff;

   // clearing pass owns the write port until it ends
   assign mem_wr_en   = (state_ff == ST_CLEAR) || (exec_go && upd_wr_en);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : upd_wr_addr;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : upd_wr_data;

   rwt_offset_mem #(
      .DEPTH (SEQ_SPACE),
      .DW    (OW)
   ) u_mem (
      .clock     (clock),
      .rd_en     (req_go),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (next_seq_ff),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data)
   );

   rwt_update #(
      .SEQ_SPACE  (SEQ_SPACE),
      .RING_BYTES (RING_BYTES)
   ) u_update (
      .op            (op_ff),
      .msg_length    (len_ff),
      .ack_idx       (ack_idx_ff),
      .next_seq      (next_seq_ff),
      .acked_seq     (acked_seq_ff),
      .rd_start      (rd_a_data),
      .rd_end        (rd_b_data),
      .rsp           (upd_rsp),
      .wr_en         (upd_wr_en),
      .wr_addr       (upd_wr_addr),
      .wr_data       (upd_wr_data),
      .next_seq_new  (upd_next_seq),
      .acked_seq_new (upd_acked_seq)
   );

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      next_seq_in   = next_seq_ff;
      acked_seq_in  = acked_seq_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + SW'(1);
            if (clr_addr_ff == SEQ_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_go) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in      = ST_IDLE;
               next_seq_in   = upd_next_seq;
               acked_seq_in  = upd_acked_seq;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         next_seq_ff   <= '0;
         acked_seq_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         next_seq_ff   <= next_seq_in;
         acked_seq_ff  <= acked_seq_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         op_ff      <= req_tuser;
         len_ff     <= req_tdata[15:0];
         ack_idx_ff <= req_ack_idx;
      end
      if (exec_go) begin
         rsp_item_ff <= upd_rsp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_item_ff};

   // a taken request always moves on to its update cycle
   a_req_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_go |=> (state_ff == ST_EXEC))
      else $error("request not followed by update cycle");

   // table is only written by the clearing pass or an update cycle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("offset table written while idle");

   // update waits while the previous response is still unread
   a_exec_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && rsp_tvalid_ff && !rsp_tready |=>
         (state_ff == ST_EXEC) && rsp_tvalid_ff)
      else $error("response overwritten");

   // sequence pointers stay inside the sequence space
   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, next_seq_ff} < SEQ_L) && ({1'b0, acked_seq_ff} < SEQ_L))
      else $error("sequence pointer out of range");

   // a finished update always presents a response
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_tvalid && (state_ff == ST_IDLE))
      else $error("update without response");

endmodule

`default_nettype wire

[sv/rwt_offset_mem.sv]
`default_nettype none

// Offset table: one write port, two read ports, registered read data.
module rwt_offset_mem #(
   parameter int DEPTH = 256,
   parameter int DW = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_a_addr,
   input  wire logic [AW-1:0] rd_b_addr,
   output logic      [DW-1:0] rd_a_data,
   output logic      [DW-1:0] rd_b_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_a_data_ff;
   logic [DW-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_data_ff <= mem_ff[rd_a_addr];
         rd_b_data_ff <= mem_ff[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

`default_nettype wire

[sv/rwt_update.sv]
`default_nettype none

// Window update: works out the response, the table write-back and the new
// sequence pointers from the two table entries read for a request.
module rwt_update import rwt_pkg::*; #(
   parameter int SEQ_SPACE = 256,
   parameter int RING_BYTES = 65536,
   localparam int SW = $clog2(SEQ_SPACE),
   localparam int OW = $clog2(RING_BYTES)
) (
   input  wire logic [1:0]    op,
   input  wire logic [15:0]   msg_length,
   input  wire logic [SW-1:0] ack_idx,
   input  wire logic [SW-1:0] next_seq,
   input  wire logic [SW-1:0] acked_seq,
   input  wire logic [OW-1:0] rd_start,
   input  wire logic [OW-1:0] rd_end,
   output rsp_item_type       rsp,
   output logic               wr_en,
   output logic      [SW-1:0] wr_addr,
   output logic      [OW-1:0] wr_data,
   output logic      [SW-1:0] next_seq_new,
   output logic      [SW-1:0] acked_seq_new
);

   localparam int MW = (OW > 16) ? OW : 16;
   localparam int LW = MW + 1;
   localparam logic [SW:0]   SEQ_L  = (SW + 1)'(SEQ_SPACE);
   localparam logic [LW-1:0] RING_L = LW'(RING_BYTES);
   localparam logic [OW:0]   RING_O = (OW + 1)'(RING_BYTES);

   function automatic logic [SW-1:0] seq_add(input logic [SW-1:0] s, input logic [1:0] k);
      logic [SW:0] sum;
      sum = {1'b0, s} + (SW + 1)'(k);
      if (sum >= SEQ_L) begin
         sum = sum - SEQ_L;
      end
      return sum[SW-1:0];
   endfunction

   logic [OW:0]     dist_raw;
   logic [OW-1:0]   used;
   logic [LW-1:0]   fill_sum;
   logic            no_space;
   logic            win_full;
   logic [LW-1:0]   end_sum;
   logic [LW-1:0]   end_wrap;
   logic [SW-1:0]   seq_p1;
   logic [SW-1:0]   acked_p1;
   logic [OW-1:0]   res_start;
   logic [MW-1:0]   res_len;
   logic            res_wraps;
   logic [SW+7:0]   seq_ext;
   logic [OW+15:0]  start_ext;
   logic [MW+15:0]  len_ext;

   always_comb begin
      // bytes outstanding between the acked and the next message
      if (rd_end >= rd_start) begin
         dist_raw = {1'b0, rd_end} - {1'b0, rd_start};
      end else begin
         dist_raw = {1'b0, rd_end} + RING_O - {1'b0, rd_start};
      end
      used = dist_raw[OW-1:0];

      fill_sum = LW'(used) + LW'(msg_length);
      no_space = (fill_sum >= RING_L);
      seq_p1   = seq_add(next_seq, 2'd1);
      acked_p1 = seq_add(acked_seq, 2'd1);
      win_full = (seq_add(next_seq, 2'd2) == acked_seq);

      // end + len stays below twice the ring once space is checked
      end_sum  = LW'(rd_end) + LW'(msg_length);
      end_wrap = (end_sum >= RING_L) ? (end_sum - RING_L) : end_sum;

      rsp           = '0;
      wr_en         = 1'b0;
      wr_addr       = seq_p1;
      wr_data       = end_wrap[OW-1:0];
      next_seq_new  = next_seq;
      acked_seq_new = acked_seq;
      res_start     = rd_end;
      res_len       = MW'(msg_length);
      seq_ext       = {8'd0, next_seq};

      case (op)
         OP_SEND: begin
            if (!win_full && !no_space) begin
               rsp.accepted = 1'b1;
               wr_en        = 1'b1;
               next_seq_new = seq_p1;
            end
         end
         OP_RESEND: begin
            rsp.accepted = 1'b1;
            wr_en        = 1'b1;
            wr_addr      = acked_p1;
            wr_data      = rd_end;
            next_seq_new = acked_p1;
            res_start    = rd_start;
            res_len      = MW'(used);
            seq_ext      = {8'd0, acked_seq};
         end
         OP_ACK: begin
            rsp.accepted  = 1'b1;
            acked_seq_new = ack_idx;
            seq_ext       = {8'd0, ack_idx};
         end
         default: begin
         end
      endcase

      res_wraps = ((LW'(res_start) + LW'(res_len)) > RING_L);
      start_ext = {16'd0, (op == OP_ACK) ? rd_start : res_start};
      len_ext   = {16'd0, res_len};

      if (rsp.accepted) begin
         rsp.seq_num      = seq_ext[7:0];
         rsp.start_offset = start_ext[15:0];
         if (op != OP_ACK) begin
            rsp.out_length = len_ext[15:0];
            rsp.wraps      = res_wraps;
         end
      end
   end

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import rwt_pkg::*;

   // op code 3 has no name in the package; the block must ignore it
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // cycles with no request or response accepted before the run is abandoned;
   // covers the table clearing pass after reset and the long response hold-off
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int REPORT_LIMIT   = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // msg_length[15:0], ack_seq[23:16]
   logic [1:0]  req_tuser  = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // accepted[0], seq_num[8:1], start_offset[24:9], out_length[40:25], wraps[41]
   logic [47:0] rsp_tdata;

   retransmit_window_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Window bookkeeping mirror: ring end offsets per sequence number, next
   // sequence to send and oldest unacked sequence. 8/16-bit vectors give the
   // modulo of the sequence space and of the byte ring for free.
   // ---------------------------------------------------------------------
   logic [15:0] ring_end [0:255] = '{default: '0};
   logic [7:0]  send_seq    = '0;
   logic [7:0]  unacked_seq = '0;

   rsp_item_type owed_rsps [$];   // responses still due, oldest first
   rsp_item_type last_owed;       // response owed by the latest request
   rsp_item_type rsp_seen;
   rsp_item_type rsp_want;

   int fail_count      = 0;
   int idle_cycles     = 0;
   int req_max_gap     = 19;
   int rsp_max_gap     = 19;
   int rsp_hold_cycles = 0;

   // Applies one request to the mirror and returns the response it owes.
   function automatic rsp_item_type advance_window(input logic [1:0] op,
         input logic [15:0] len, input logic [7:0] ack);
      rsp_item_type r;
      logic [15:0]  head;
      logic [15:0]  tail;
      logic [15:0]  in_flight;
      logic [7:0]   seq_after;
      logic [7:0]   two_ahead;
      r = '0;
      head      = ring_end[unacked_seq];
      tail      = ring_end[send_seq];
      in_flight = tail - head;
      two_ahead = send_seq + 8'd2;
      case (op)
         OP_SEND: begin
            // rejected when the window is full or the bytes would not fit
            if (two_ahead != unacked_seq &&
                ({1'b0, in_flight} + {1'b0, len}) < 17'h10000) begin
               seq_after = send_seq + 8'd1;
               ring_end[seq_after] = tail + len;
               r.accepted     = 1'b1;
               r.seq_num      = send_seq;
               r.start_offset = tail;
               r.out_length   = len;
               r.wraps        = ({1'b0, tail} + {1'b0, len}) > 17'h10000;
               send_seq = seq_after;
            end
         end
         OP_RESEND: begin
            // everything outstanding folds into one message at the acked seq
            seq_after = unacked_seq + 8'd1;
            ring_end[seq_after] = tail;
            r.accepted     = 1'b1;
            r.seq_num      = unacked_seq;
            r.start_offset = head;
            r.out_length   = in_flight;
            r.wraps        = ({1'b0, head} + {1'b0, in_flight}) > 17'h10000;
            send_seq = seq_after;
         end
         OP_ACK: begin
            // no check against send_seq: any value is taken as is
            unacked_seq    = ack;
            r.accepted     = 1'b1;
            r.seq_num      = ack;
            r.start_offset = ring_end[ack];
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offers one request after a random gap, holds it until accepted, then
   // books the owed response. Returns just after the accepting rising edge.
   task automatic send_request(input logic [1:0] op, input logic [15:0] len,
         input logic [7:0] ack);
      int gap;
      gap = $urandom_range(req_max_gap, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ack, len};
      do @(posedge clock); while (!req_tready);
      last_owed = advance_window(op, len, ack);
      owed_rsps.push_back(last_owed);
   endtask

   // Response side: per response, a random stall (plus any requested long
   // hold-off), then ready until one response is taken.
   initial begin : rsp_side
      int stall;
      forever begin
         @(negedge clock);
         stall = rsp_hold_cycles + $urandom_range(rsp_max_gap, 0);
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Response checker: every accepted response against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen = rsp_tdata[41:0];
         if (owed_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: response %h with no request outstanding", $time, rsp_tdata);
         end else begin
            rsp_want = owed_rsps.pop_front();
            if (rsp_seen.accepted     !== rsp_want.accepted     ||
                rsp_seen.seq_num      !== rsp_want.seq_num      ||
                rsp_seen.start_offset !== rsp_want.start_offset ||
                rsp_seen.out_length   !== rsp_want.out_length   ||
                rsp_seen.wraps        !== rsp_want.wraps) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: mismatch exp acc=%0d seq=%0d start=%0d len=%0d wraps=%0d, got acc=%0d seq=%0d start=%0d len=%0d wraps=%0d",
                           $time, rsp_want.accepted, rsp_want.seq_num,
                           rsp_want.start_offset, rsp_want.out_length, rsp_want.wraps,
                           rsp_seen.accepted, rsp_seen.seq_num,
                           rsp_seen.start_offset, rsp_seen.out_length, rsp_seen.wraps);
            end
         end
      end
   end

   // Watchdog: abandon the run after too long without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, ring space boundary, wrap past the ring end, empty
   // resend, full window, extreme ack values and the unused op code.
   task automatic test_directed_extremes();
      send_request(OP_SEND,   16'd0,     8'hFF);
      send_request(OP_SEND,   16'hFFFF,  8'h00);   // fills all but one byte
      send_request(OP_SEND,   16'd1,     8'h00);   // no space left
      send_request(OP_SEND,   16'd0,     8'h00);   // zero length still fits
      send_request(OP_RESEND, 16'hFFFF,  8'hFF);
      send_request(OP_ACK,    16'd0,     send_seq);
      send_request(OP_RESEND, 16'd0,     8'h00);   // nothing outstanding
      send_request(OP_SEND,   16'd2,     8'h00);   // starts at last ring byte
      send_request(OP_SEND,   16'hFFFF,  8'h00);   // no space
      send_request(OP_ACK,    16'hFFFF,  send_seq);
      send_request(OP_SEND,   16'hFFFE,  8'hFF);
      send_request(OP_ACK,    16'd0,     send_seq);
      send_request(OP_SEND,   16'hFFFF,  8'h00);
      send_request(OP_ACK,    16'd0,     send_seq + 8'd2);   // window full
      send_request(OP_SEND,   16'd10,    8'h00);
      send_request(OP_ACK,    16'd0,     8'hFF);
      send_request(OP_ACK,    16'hFFFF,  8'h00);
      send_request(OP_ACK,    16'd0,     send_seq);
      send_request(OP_UNUSED, 16'hFFFF,  8'hFF);
      send_request(OP_UNUSED, 16'd0,     8'h00);
      send_request(OP_RESEND, 16'd0,     8'h00);
   endtask

   // Send small messages from an empty window until it refuses more.
   task automatic test_window_full();
      int refused;
      int sent;
      refused = 0;
      sent    = 0;
      send_request(OP_ACK, 16'($urandom), send_seq);
      while (refused < 3 && sent < 270) begin
         send_request(OP_SEND, 16'($urandom_range(200, 0)), 8'($urandom));
         sent++;
         if (!last_owed.accepted)
            refused++;
      end
      // free half of it and push on
      send_request(OP_ACK, 16'($urandom), unacked_seq + 8'd128);
      repeat (4)
         send_request(OP_SEND, 16'($urandom_range(200, 0)), 8'($urandom));
   endtask

   // Response side stops for a long stretch while requests keep coming
   // back to back, so the block backs up and drops req_tready.
   task automatic test_backpressure();
      req_max_gap     = 0;
      rsp_hold_cycles = HOLD_CYCLES;
      send_request(OP_ACK, 16'($urandom), send_seq);
      repeat (40)
         send_request(OP_SEND, 16'($urandom_range(800, 0)), 8'($urandom));
   endtask

   // Mostly well-formed traffic: sends, acks within the window and resends;
   // the rest is acks of any value and the unused op code.
   task automatic test_random(input int count);
      int          pick;
      int          len_kind;
      logic [7:0]  backlog;
      logic [16:0] room;
      logic [15:0] len;
      repeat (count) begin
         pick     = $urandom_range(99, 0);
         len_kind = $urandom_range(9, 0);
         backlog  = send_seq - unacked_seq;
         room     = 17'h10000 - {1'b0, ring_end[send_seq] - ring_end[unacked_seq]};
         if (len_kind == 0)
            len = 16'($urandom);
         else if (len_kind == 1)
            len = 16'(room - 17'($urandom_range(1, 0)));   // right at the space limit
         else
            len = 16'($urandom_range(1500, 0));
         if (pick < 60)
            send_request(OP_SEND, len, 8'($urandom));
         else if (pick < 80)
            send_request(OP_ACK, 16'($urandom),
                         unacked_seq + 8'($urandom_range(backlog, 0)));
         else if (pick < 88)
            send_request(OP_RESEND, 16'($urandom), 8'($urandom));
         else if (pick < 95)
            send_request(OP_ACK, 16'($urandom), 8'($urandom));
         else
            send_request(OP_UNUSED, 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_directed_extremes();
      test_window_full();
      test_backpressure();

      req_max_gap = 19;
      rsp_max_gap = 19;
      test_random(500);
      req_max_gap = 0;    // no idling on either side
      rsp_max_gap = 0;
      test_random(300);
      req_max_gap = 19;
      test_random(400);
      req_max_gap = 0;
      rsp_max_gap = 19;
      test_random(420);

      @(negedge clock) req_tvalid <= 1'b0;
      while (owed_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
